// ===== design/crs_pkg.sv =====
// Shared types, request codes and saturation helper for the clip rectangle stack.
// No dependencies; every other design file depends on this package.
`timescale 1ns / 1ps

package crs_pkg;

    localparam int CFG_IDX_W = 2;

    localparam logic [1:0] REQ_PUSH  = 2'd0;
    localparam logic [1:0] REQ_POP   = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_HEIGHT = 2'd1;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] w;
        logic signed [15:0] h;
        logic signed [15:0] sx;
        logic signed [15:0] sy;
    } entry_t;

    typedef struct packed {
        logic push;
        logic pop;
    } cell_ctl_t;

    typedef struct packed {
        logic load;
        logic origin;
        logic trim;
        logic fit;
    } clip_ctl_t;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_ORIGIN = 5'b00010,
        ST_TRIM   = 5'b00100,
        ST_FIT    = 5'b01000,
        ST_COMMIT = 5'b10000
    } state_t;

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v > 18'sd32767)
            r = 16'sh7fff;
        else if (v < -18'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

endpackage

// ===== design/crs_if.sv =====
// Handshake interfaces for the request, response and configuration channels.
// Depends on crs_pkg for the configuration index width.
`timescale 1ns / 1ps

interface crs_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic signed [15:0] rect_x;
    logic signed [15:0] rect_y;
    logic signed [15:0] rect_width;
    logic signed [15:0] rect_height;

    modport source (output valid, req_type, rect_x, rect_y, rect_width, rect_height,
                    input ready);
    modport sink   (input valid, req_type, rect_x, rect_y, rect_width, rect_height,
                    output ready);
endinterface

interface crs_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] top_x;
    logic signed [15:0] top_y;
    logic signed [15:0] top_width;
    logic signed [15:0] top_height;
    logic signed [15:0] shift_x;
    logic signed [15:0] shift_y;
    logic [3:0]         level;
    logic               overflow;

    modport source (output valid, top_x, top_y, top_width, top_height, shift_x, shift_y,
                    level, overflow, input ready);
    modport sink   (input valid, top_x, top_y, top_width, top_height, shift_x, shift_y,
                    level, overflow, output ready);
endinterface

interface crs_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [crs_pkg::CFG_IDX_W-1:0]  index;
    logic [14:0]                    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/clip_rect_stack.sv =====
// Top level of the clip rectangle stack: control sequencer, chain of stack cells,
// configuration registers and response register. Uses crs_pkg, crs_if, crs_cell, crs_clip.
//
// Usage:
//   req  : one transaction per request (push rectangle, pop, clear to base).
//   rsp  : exactly one transaction per request with the resulting top viewport,
//          its translate offset, the level and a push overflow flag.
//   cfg  : register writes (display width, display height), always ready;
//          write only while no request is in flight.
// Timing:
//   A request is taken in the idle step, then passes origin, trim and fit steps of
//   the clip datapath and commits in the commit step; no new request is taken until
//   it has committed. Its response is registered at commit. The sequence is set
//   by the three registered steps of the shared clip datapath.
//   The stack is a row of STACK_DEPTH-1 cells with the top in cell 0; push and pop
//   shift every cell by one place in the commit cycle. The base entry is implicit.
// Reset: level 0 (base viewport all zero), display size 640 x 480, no response.
// Stall: a waiting response holds in its register; the next request is still taken
//   and waits in the commit step until the response register frees.
`timescale 1ns / 1ps

module clip_rect_stack #(
    parameter int STACK_DEPTH = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    crs_req_if.sink   req,
    crs_rsp_if.source rsp,
    crs_cfg_if.sink   cfg
);
    import crs_pkg::*;

    localparam int NCELL = STACK_DEPTH - 1;
    localparam int LVL_W = $clog2(STACK_DEPTH);

    state_t             state_reg, state_next;
    logic [LVL_W-1:0]   lvl_reg, lvl_next;
    logic [1:0]         req_type_reg;
    logic [14:0]        disp_w_reg, disp_h_reg;
    logic               rsp_valid_reg;
    entry_t             rsp_ent_reg, rsp_ent_next;
    logic [LVL_W-1:0]   rsp_lvl_reg;
    logic               rsp_ovf_reg, rsp_ovf_next;

    entry_t             cell_q [NCELL+1];
    entry_t             parent;
    entry_t             cur_top;
    entry_t             clip_res;
    clip_ctl_t          clip_ctl;
    cell_ctl_t          cell_ctl;
    logic               accept;
    logic               commit;
    logic               full;
    logic               do_push;
    logic               do_pop;

    assign accept = req.valid && req.ready;
    assign commit = (state_reg == ST_COMMIT) && (!rsp_valid_reg || rsp.ready);
    assign full   = (lvl_reg == LVL_W'(STACK_DEPTH - 1));
    assign do_push = (req_type_reg == REQ_PUSH) && !full;
    assign do_pop  = (req_type_reg == REQ_POP) && (lvl_reg != '0);

    assign req.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;

    always_comb
    begin
        if (lvl_reg == '0)
        begin
            parent   = '0;
            parent.w = 16'(disp_w_reg);
            parent.h = 16'(disp_h_reg);
        end
        else
        begin
            parent = cell_q[0];
        end
    end

    assign cur_top = (lvl_reg == '0) ? '0 : cell_q[0];

    assign clip_ctl.load   = accept;
    assign clip_ctl.origin = (state_reg == ST_ORIGIN);
    assign clip_ctl.trim   = (state_reg == ST_TRIM);
    assign clip_ctl.fit    = (state_reg == ST_FIT);

    assign cell_ctl.push = commit && do_push;
    assign cell_ctl.pop  = commit && do_pop;

    crs_clip u_clip (
        .clk         (clk),
        .ctl         (clip_ctl),
        .rect_x      (req.rect_x),
        .rect_y      (req.rect_y),
        .rect_width  (req.rect_width),
        .rect_height (req.rect_height),
        .parent      (parent),
        .result      (clip_res)
    );

    assign cell_q[NCELL] = '0;

    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            crs_cell u_cell (
                .clk       (clk),
                .ctl       (cell_ctl),
                .from_prev (clip_res),
                .from_next (cell_q[i+1]),
                .q         (cell_q[i])
            );
        end
        else
        begin : g_body
            crs_cell u_cell (
                .clk       (clk),
                .ctl       (cell_ctl),
                .from_prev (cell_q[i-1]),
                .from_next (cell_q[i+1]),
                .q         (cell_q[i])
            );
        end
    end

    always_comb
    begin
        lvl_next     = lvl_reg;
        rsp_ent_next = cur_top;
        rsp_ovf_next = 1'b0;
        case (req_type_reg)
            REQ_PUSH:
            begin
                if (full)
                begin
                    rsp_ovf_next = 1'b1;
                end
                else
                begin
                    lvl_next     = lvl_reg + LVL_W'(1);
                    rsp_ent_next = clip_res;
                end
            end
            REQ_POP:
            begin
                if (lvl_reg != '0)
                begin
                    lvl_next     = lvl_reg - LVL_W'(1);
                    rsp_ent_next = (lvl_reg > LVL_W'(1)) ? cell_q[1] : '0;
                end
            end
            REQ_CLEAR:
            begin
                lvl_next     = '0;
                rsp_ent_next = '0;
            end
            default:
            begin
                rsp_ent_next = cur_top;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (accept) state_next = ST_ORIGIN;
            ST_ORIGIN: state_next = ST_TRIM;
            ST_TRIM:   state_next = ST_FIT;
            ST_FIT:    state_next = ST_COMMIT;
            ST_COMMIT: if (commit) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            lvl_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            disp_w_reg    <= 15'd640;
            disp_h_reg    <= 15'd480;
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
                lvl_reg <= lvl_next;
            if (commit)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
            if (cfg.valid && cfg.index == REG_DISPLAY_WIDTH)
                disp_w_reg <= cfg.data;
            if (cfg.valid && cfg.index == REG_DISPLAY_HEIGHT)
                disp_h_reg <= cfg.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            req_type_reg <= req.req_type;
        if (commit)
        begin
            rsp_ent_reg <= rsp_ent_next;
            rsp_lvl_reg <= lvl_next;
            rsp_ovf_reg <= rsp_ovf_next;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.top_x      = rsp_ent_reg.x;
    assign rsp.top_y      = rsp_ent_reg.y;
    assign rsp.top_width  = rsp_ent_reg.w;
    assign rsp.top_height = rsp_ent_reg.h;
    assign rsp.shift_x    = rsp_ent_reg.sx;
    assign rsp.shift_y    = rsp_ent_reg.sy;
    assign rsp.level      = 4'(rsp_lvl_reg);
    assign rsp.overflow   = rsp_ovf_reg;

`ifndef SYNTHESIS
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(lvl_reg) <= STACK_DEPTH - 1)
        else $error("stack level beyond depth");

    a_push_step: assert property (@(posedge clk) disable iff (!rst_n)
        commit && do_push |=> lvl_reg == $past(lvl_reg) + LVL_W'(1))
        else $error("push did not advance level");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_ovf_reg |-> 32'(rsp_lvl_reg) == STACK_DEPTH - 1)
        else $error("overflow flagged below full stack");

    a_base_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_lvl_reg == '0 |-> rsp_ent_reg == '0)
        else $error("base viewport response not zero");
`endif

endmodule

// ===== design/crs_cell.sv =====
// One stack cell: holds one viewport entry and shifts toward either neighbor.
// Depends on crs_pkg for entry_t and cell_ctl_t.
`timescale 1ns / 1ps

module crs_cell (
    input  logic               clk,
    input  crs_pkg::cell_ctl_t ctl,
    input  crs_pkg::entry_t    from_prev,
    input  crs_pkg::entry_t    from_next,
    output crs_pkg::entry_t    q
);
    import crs_pkg::*;

    entry_t q_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.push)
            q_reg <= from_prev;
        else if (ctl.pop)
            q_reg <= from_next;
    end

    assign q = q_reg;

endmodule

// ===== design/crs_clip.sv =====
// Clip datapath: offsets a pushed rectangle by its parent and clips it in three steps.
// Depends on crs_pkg for entry_t, clip_ctl_t and sat16.
`timescale 1ns / 1ps

module crs_clip (
    input  logic               clk,
    input  crs_pkg::clip_ctl_t ctl,
    input  logic signed [15:0] rect_x,
    input  logic signed [15:0] rect_y,
    input  logic signed [15:0] rect_width,
    input  logic signed [15:0] rect_height,
    input  crs_pkg::entry_t    parent,
    output crs_pkg::entry_t    result
);
    import crs_pkg::*;

    logic signed [15:0] rx_reg, ry_reg, rw_reg, rh_reg;
    logic signed [15:0] px_reg, py_reg, pw_reg, ph_reg, psx_reg, psy_reg;
    logic signed [15:0] nx0_reg, ny0_reg, pex_reg, pey_reg;
    logic signed [15:0] nx1_reg, ny1_reg, nw1_reg, nh1_reg, tx_reg, ty_reg;
    entry_t             res_reg;

    logic signed [17:0] dx_next, dy_next;
    logic signed [15:0] nx1_next, ny1_next, nw1_next, nh1_next, tx_next, ty_next;
    logic signed [15:0] nx2_next, ny2_next, nw2_next, nh2_next;
    logic signed [16:0] ex_sum, ey_sum;

    // overshoot past the parent's near edge
    always_comb
    begin
        dx_next = 18'(rw_reg) - (18'(px_reg) - 18'(nx0_reg));
        dy_next = 18'(rh_reg) - (18'(py_reg) - 18'(ny0_reg));
        if (nx0_reg < px_reg)
        begin
            tx_next  = sat16(18'(nx0_reg) - 18'(px_reg));
            nw1_next = dx_next[17] ? 16'sd0 : dx_next[15:0];
            nx1_next = px_reg;
        end
        else
        begin
            tx_next  = psx_reg;
            nw1_next = rw_reg;
            nx1_next = nx0_reg;
        end
        if (ny0_reg < py_reg)
        begin
            ty_next  = sat16(18'(ny0_reg) - 18'(py_reg));
            nh1_next = dy_next[17] ? 16'sd0 : dy_next[15:0];
            ny1_next = py_reg;
        end
        else
        begin
            ty_next  = psy_reg;
            nh1_next = rh_reg;
            ny1_next = ny0_reg;
        end
    end

    // fit inside the parent's far edge
    always_comb
    begin
        nx2_next = (nx1_reg > pex_reg) ? pex_reg : nx1_reg;
        ny2_next = (ny1_reg > pey_reg) ? pey_reg : ny1_reg;
        ex_sum   = 17'(nx2_next) + 17'(nw1_reg);
        ey_sum   = 17'(ny2_next) + 17'(nh1_reg);
        nw2_next = (ex_sum > 17'(pex_reg)) ? sat16(18'(pex_reg) - 18'(nx2_next)) : nw1_reg;
        nh2_next = (ey_sum > 17'(pey_reg)) ? sat16(18'(pey_reg) - 18'(ny2_next)) : nh1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            rx_reg  <= rect_x;
            ry_reg  <= rect_y;
            rw_reg  <= rect_width;
            rh_reg  <= rect_height;
            px_reg  <= parent.x;
            py_reg  <= parent.y;
            pw_reg  <= parent.w;
            ph_reg  <= parent.h;
            psx_reg <= parent.sx;
            psy_reg <= parent.sy;
        end
        if (ctl.origin)
        begin
            nx0_reg <= sat16(18'(rx_reg) + 18'(px_reg));
            ny0_reg <= sat16(18'(ry_reg) + 18'(py_reg));
            pex_reg <= sat16(18'(px_reg) + 18'(pw_reg));
            pey_reg <= sat16(18'(py_reg) + 18'(ph_reg));
        end
        if (ctl.trim)
        begin
            nx1_reg <= nx1_next;
            ny1_reg <= ny1_next;
            nw1_reg <= nw1_next;
            nh1_reg <= nh1_next;
            tx_reg  <= tx_next;
            ty_reg  <= ty_next;
        end
        if (ctl.fit)
        begin
            res_reg.x  <= nx2_next;
            res_reg.y  <= ny2_next;
            res_reg.w  <= nw2_next;
            res_reg.h  <= nh2_next;
            res_reg.sx <= tx_reg;
            res_reg.sy <= ty_reg;
        end
    end

    assign result = res_reg;

endmodule

// ===== test/tb.sv =====
// Testbench for clip_rect_stack: push, pop, clear and unused-code requests under random idling,
// checked in order against a scoreboard that keeps its own copy of the viewport stack.
// Depends on crs_pkg, the crs_if interfaces and the clip_rect_stack design files.
`timescale 1ns / 1ps

module tb;
    import crs_pkg::*;

    localparam int DEPTH = 16;
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_AT = 60;
    localparam int HOLD_CYCLES = 120;
    localparam int PHASE_ITEMS = 220;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] w;
        logic signed [15:0] h;
    } request_t;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] w;
        logic signed [15:0] h;
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic [3:0]         level;
        logic               overflow;
    } viewport_t;

    function automatic int clamp16(int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    class viewport_scoreboard;
        entry_t    stack_mem[DEPTH];
        int        top;
        int        disp_w;
        int        disp_h;
        viewport_t expected[$];
        int        failures;

        function new();
            foreach (stack_mem[i])
                stack_mem[i] = '0;
            top = 0;
            disp_w = 640;
            disp_h = 480;
            failures = 0;
        endfunction

        function void set_display(logic [CFG_IDX_W-1:0] idx, logic [14:0] val);
            if (idx == REG_DISPLAY_WIDTH)
                disp_w = int'(val);
            else if (idx == REG_DISPLAY_HEIGHT)
                disp_h = int'(val);
        endfunction

        function void push_rect(request_t rq);
            entry_t par;
            entry_t kid;
            int px, py, pw, ph, nx, ny, nw, nh, tx, ty, pex, pey;
            par = stack_mem[top];
            px = par.x;
            py = par.y;
            pw = par.w;
            ph = par.h;
            tx = par.sx;
            ty = par.sy;
            if (top == 0)
            begin
                pw = disp_w;
                ph = disp_h;
            end
            nx = clamp16(int'(rq.x) + px);
            ny = clamp16(int'(rq.y) + py);
            nw = rq.w;
            nh = rq.h;
            if (nx < px)
            begin
                tx = clamp16(nx - px);
                nw = clamp16(nw - (px - nx));
                nx = px;
                if (nw < 0)
                    nw = 0;
            end
            if (ny < py)
            begin
                ty = clamp16(ny - py);
                nh = clamp16(nh - (py - ny));
                ny = py;
                if (nh < 0)
                    nh = 0;
            end
            pex = clamp16(px + pw);
            pey = clamp16(py + ph);
            if (nx > pex)
                nx = pex;
            if (ny > pey)
                ny = pey;
            if (nx + nw > pex)
                nw = clamp16(pex - nx);
            if (ny + nh > pey)
                nh = clamp16(pey - ny);
            kid.x = 16'(nx);
            kid.y = 16'(ny);
            kid.w = 16'(nw);
            kid.h = 16'(nh);
            kid.sx = 16'(tx);
            kid.sy = 16'(ty);
            top = top + 1;
            stack_mem[top] = kid;
        endfunction

        function void note_request(request_t rq);
            viewport_t v;
            v.overflow = 1'b0;
            case (rq.kind)
                REQ_PUSH:
                    if (top == DEPTH - 1)
                        v.overflow = 1'b1;
                    else
                        push_rect(rq);
                REQ_POP:
                    if (top != 0)
                        top = top - 1;
                REQ_CLEAR:
                begin
                    top = 0;
                    stack_mem[0] = '0;
                end
                default: ;
            endcase
            v.x = stack_mem[top].x;
            v.y = stack_mem[top].y;
            v.w = stack_mem[top].w;
            v.h = stack_mem[top].h;
            v.sx = stack_mem[top].sx;
            v.sy = stack_mem[top].sy;
            v.level = 4'(top);
            expected = {expected, v};
        endfunction

        function string show(viewport_t v);
            return $sformatf("x=%0d y=%0d w=%0d h=%0d sx=%0d sy=%0d level=%0d ovf=%0b",
                             v.x, v.y, v.w, v.h, v.sx, v.sy, v.level, v.overflow);
        endfunction

        function void check_response(viewport_t got);
            viewport_t want;
            if (expected.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("response with nothing pending: %s", show(got));
                return;
            end
            want = expected.pop_front();
            if (got !== want)
            begin
                failures++;
                if (failures <= 10)
                begin
                    $display("response mismatch at %0t ns", $time);
                    $display("  expected %s", show(want));
                    $display("  actual   %s", show(got));
                end
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    bit   no_idle = 1'b0;

    crs_req_if req_ch ();
    crs_rsp_if rsp_ch ();
    crs_cfg_if cfg_ch ();

    viewport_scoreboard sb = new();

    clip_rect_stack uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic request_t make_req(logic [1:0] k, int x, int y, int w, int h);
        request_t rq;
        rq.kind = k;
        rq.x = 16'(x);
        rq.y = 16'(y);
        rq.w = 16'(w);
        rq.h = 16'(h);
        return rq;
    endfunction

    function automatic int pick_value();
        int v;
        case ($urandom_range(0, 9))
            0, 1:    v = int'($urandom_range(0, 65535)) - 32768;
            2:
                case ($urandom_range(0, 5))
                    0:       v = -32768;
                    1:       v = 32767;
                    2:       v = -1;
                    3:       v = 0;
                    4:       v = 1;
                    default: v = -32767;
                endcase
            3:       v = int'($urandom_range(0, 16)) - 8;
            default: v = int'($urandom_range(0, 1000)) - 200;
        endcase
        return v;
    endfunction

    function automatic request_t random_request(int push_pct);
        int         r;
        logic [1:0] k;
        r = $urandom_range(0, 99);
        if (r < push_pct)
            k = REQ_PUSH;
        else if (r < 92)
            k = REQ_POP;
        else if (r < 97)
            k = REQ_CLEAR;
        else
            k = REQ_UNUSED;
        return make_req(k, pick_value(), pick_value(), pick_value(), pick_value());
    endfunction

    task automatic send_request(request_t rq);
        req_ch.valid <= 1'b1;
        req_ch.req_type <= rq.kind;
        req_ch.rect_x <= rq.x;
        req_ch.rect_y <= rq.y;
        req_ch.rect_width <= rq.w;
        req_ch.rect_height <= rq.h;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        sb.note_request(rq);
    endtask

    task automatic idle_gap();
        if (!no_idle && $urandom_range(0, 5) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        while (sb.expected.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_display(logic [14:0] w, logic [14:0] h);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= REG_DISPLAY_WIDTH;
        cfg_ch.data <= w;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        sb.set_display(REG_DISPLAY_WIDTH, w);
        cfg_ch.index <= REG_DISPLAY_HEIGHT;
        cfg_ch.data <= h;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        sb.set_display(REG_DISPLAY_HEIGHT, h);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic run_directed();
        request_t plan[$];
        plan = {plan, make_req(REQ_PUSH, 0, 0, 640, 480)};
        plan = {plan, make_req(REQ_PUSH, -32768, -32768, 32767, 32767)};
        plan = {plan, make_req(REQ_POP, 0, 0, 0, 0)};
        plan = {plan, make_req(REQ_PUSH, 32767, 32767, -32768, -32768)};
        plan = {plan, make_req(REQ_PUSH, 100, 50, -20, -30)};
        plan = {plan, make_req(REQ_POP, 0, 0, 0, 0)};
        plan = {plan, make_req(REQ_POP, 0, 0, 0, 0)};
        plan = {plan, make_req(REQ_POP, -1, -1, -1, -1)};
        plan = {plan, make_req(REQ_CLEAR, 0, 0, 0, 0)};
        for (int i = 0; i < DEPTH - 1; i++)
            plan = {plan, make_req(REQ_PUSH, i * 7 - 20, 9 - i * 3, 700 - i * 45, i * 40 - 5)};
        plan = {plan, make_req(REQ_PUSH, 1, 1, 10, 10)};
        plan = {plan, make_req(REQ_UNUSED, -32768, 32767, -32768, 32767)};
        plan = {plan, make_req(REQ_POP, 0, 0, 0, 0)};
        plan = {plan, make_req(REQ_PUSH, -5, -5, 3, 3)};
        plan = {plan, make_req(REQ_CLEAR, 32767, 32767, 32767, 32767)};
        foreach (plan[i])
        begin
            send_request(plan[i]);
            idle_gap();
        end
        req_ch.valid <= 1'b0;
    endtask

    task automatic run_random(int count);
        int push_pct;
        push_pct = 70;
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
                push_pct = $urandom_range(0, 1) ? 70 : 35;
            send_request(random_request(push_pct));
            idle_gap();
        end
        req_ch.valid <= 1'b0;
    endtask

    initial
    begin
        rst_n <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.req_type <= REQ_PUSH;
        req_ch.rect_x <= '0;
        req_ch.rect_y <= '0;
        req_ch.rect_width <= '0;
        req_ch.rect_height <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= REG_DISPLAY_WIDTH;
        cfg_ch.data <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        wait_drained();
        write_display(15'd0, 15'd0);
        run_random(PHASE_ITEMS);
        wait_drained();
        write_display(15'd32767, 15'd32767);
        run_random(PHASE_ITEMS);
        wait_drained();
        write_display(15'($urandom_range(0, 32767)), 15'($urandom_range(0, 32767)));
        run_random(PHASE_ITEMS);
        wait_drained();
        write_display(15'd1, 15'd32767);
        run_random(PHASE_ITEMS);
        wait_drained();
        write_display(15'd32767, 15'd1);
        run_random(PHASE_ITEMS);
        wait_drained();
        no_idle = 1'b1;
        write_display(15'd640, 15'd480);
        run_random(PHASE_ITEMS);
        wait_drained();
        repeat (12) @(posedge clk);
        if (sb.failures == 0 && sb.expected.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        int        stall_left;
        int        seen;
        bit        held;
        viewport_t got;
        stall_left = 0;
        seen = 0;
        held = 1'b0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            begin
                got.x = rsp_ch.top_x;
                got.y = rsp_ch.top_y;
                got.w = rsp_ch.top_width;
                got.h = rsp_ch.top_height;
                got.sx = rsp_ch.shift_x;
                got.sy = rsp_ch.shift_y;
                got.level = rsp_ch.level;
                got.overflow = rsp_ch.overflow;
                sb.check_response(got);
                seen++;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (!held && seen >= HOLD_AT)
            begin
                held = 1'b1;
                stall_left = HOLD_CYCLES - 1;
                rsp_ch.ready <= 1'b0;
            end
            else if (!no_idle && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(0, 6);
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
                (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) ||
                (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("FAIL");
        $finish;
    end

endmodule
